FILE: sv/tcopw_pkg.sv
// Shared types, constants and step decode for the OLED page-mode text writer.
// No dependencies; imported by tcopw_fmt and the top level.
package tcopw_pkg;

	// Default geometry and font size
	localparam int unsigned DEF_TEXT_COLUMNS = 16;
	localparam int unsigned DEF_TEXT_ROWS    = 4;
	localparam int unsigned DEF_GLYPH_COUNT  = 95;

	localparam int unsigned GLYPH_BYTES    = 16;
	localparam int unsigned HALF_STEPS     = 11;  // 3 commands + 8 data bytes per page
	localparam int unsigned STEPS_PER_CHAR = 22;

	localparam logic [7:0] PAGE_UPPER  = 8'hB7;
	localparam logic [7:0] PAGE_LOWER  = 8'hB6;
	localparam logic [7:0] COL_LO_MASK = 8'h0F;
	localparam logic [7:0] COL_HI_CMD  = 8'h10;
	localparam logic [7:0] CHAR_FIRST  = 8'h20;
	localparam logic [7:0] CHAR_LAST   = 8'h7E;
	localparam logic [2:0] ROW_MAX     = 3'd7;

	// Action codes
	localparam logic [1:0] ACT_PUT  = 2'd0;
	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_LOAD = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [2:0] row;
		logic [4:0] column;
		logic [6:0] glyph_index;
		logic [3:0] glyph_byte;
		logic [7:0] font_value;
	} item_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic       is_data;
		logic [1:0] status;
		logic       last;
	} result_t;

	typedef enum logic [1:0] {
		K_PAGE  = 2'd0,
		K_COLLO = 2'd1,
		K_COLHI = 2'd2,
		K_DATA  = 2'd3
	} step_kind_t;

	// What a step of the 22-beat character burst carries
	function automatic step_kind_t step_kind(input logic [4:0] step);
		logic [4:0] sub;
		sub = (step < 5'(HALF_STEPS)) ? step : 5'(step - 5'(HALF_STEPS));
		unique case (sub)
			5'd0:    step_kind = K_PAGE;
			5'd1:    step_kind = K_COLLO;
			5'd2:    step_kind = K_COLHI;
			default: step_kind = K_DATA;
		endcase
	endfunction

endpackage

FILE: sv/tcopw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcopw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1520
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/tcopw_fmt.sv
// Byte formatter shared by every beat of a character burst: page, column or glyph byte.
// Depends on tcopw_pkg.
module tcopw_fmt
	import tcopw_pkg::*;
(
	input  logic [4:0] step,
	input  logic [2:0] row,
	input  logic [4:0] column,
	input  logic [7:0] glyph_data,
	output logic [7:0] out_byte,
	output logic       is_data
);

	logic [7:0] page_base;
	logic [7:0] page_byte;
	logic [7:0] colpix;

	// One subtractor serves both page commands
	assign page_base = (step < 5'(HALF_STEPS)) ? PAGE_UPPER : PAGE_LOWER;
	assign page_byte = page_base - {4'd0, row, 1'b0};
	assign colpix    = {column, 3'b000};

	always_comb begin
		is_data = 1'b0;
		unique case (step_kind(step))
			K_PAGE:  out_byte = page_byte;
			K_COLLO: out_byte = colpix & COL_LO_MASK;
			K_COLHI: out_byte = (colpix >> 4) | COL_HI_CMD;
			K_DATA: begin
				out_byte = glyph_data;
				is_data  = 1'b1;
			end
			default: out_byte = 8'd0;
		endcase
	end

endmodule

FILE: sv/text_cursor_oled_page_writer_core.sv
// Top level of the OLED page-mode text writer: sequencer, cursor and font store.
// Depends on tcopw_pkg, tcopw_ram and tcopw_fmt.
//
// Usage:
//  - Command channel: an item beat is taken on a rising edge with start high and
//    busy low. Fields travel as item_t.
//  - Result channel: strobe marks a result_t beat, held for exactly one cycle.
//    The receiver cannot stall; every beat must be captured when strobe is high.
//  - Font load: written straight into the font store on the accept edge; no
//    result, busy never rises, a new beat may follow in the next cycle.
//  - Set cursor: one result beat on the cycle after accept; busy stays low.
//  - Put character: busy rises for the check state and stays high through the
//    emit steps, one result beat per cycle (6 command bytes, 16 glyph bytes);
//    the first beat is registered in the first emit step. A rejected or screen-full
//    character gives a single status beat after the check cycle. A new character
//    is taken only once the burst ends and busy falls, since one byte formatter
//    and one font-store read port serve the whole burst.
//  - Reset (arst_n low) returns the cursor to row 0, column 0 and drops strobe.
//    The font store is not cleared; glyphs must be loaded before they are drawn.
module text_cursor_oled_page_writer_core
	import tcopw_pkg::*;
#(
	parameter int unsigned TEXT_COLUMNS = DEF_TEXT_COLUMNS,
	parameter int unsigned TEXT_ROWS    = DEF_TEXT_ROWS,
	parameter int unsigned GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	localparam int unsigned STORE_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHECK = 3'b010,
		S_EMIT  = 3'b100
	} state_t;

	state_t      state_q;
	logic [4:0]  col_q;
	logic [2:0]  row_q;
	logic [4:0]  step_q;
	logic [3:0]  ptr_q;
	logic [7:0]  char_q;
	logic [6:0]  glyph_q;
	logic        strobe_q;
	result_t     res_q;

	logic        accept;
	logic        glyph_in_range;
	logic        ram_we;
	logic        ram_re;
	logic [10:0] waddr_full;
	logic [10:0] raddr_full;
	logic [7:0]  ram_rdata;
	logic [7:0]  fmt_byte;
	logic        fmt_is_data;

	// Character check and cursor wrap, used in the check cycle
	logic [6:0]  glyph_w;
	logic        code_ok;
	logic        wrap;
	logic [4:0]  col_w;
	logic [2:0]  row_w;
	logic        full_w;
	logic        pos_bad;
	logic        last_step;
	logic [4:0]  step_next;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Font store write port: one byte per load beat
	assign glyph_in_range = ({1'b0, item.glyph_index} < 8'(GLYPH_COUNT));
	assign ram_we         = accept && (item.action == ACT_LOAD) && glyph_in_range;
	assign waddr_full     = {item.glyph_index, item.glyph_byte};

	// Read one beat ahead: registered read data lines up with the data step
	assign step_next  = 5'(step_q + 5'd1);
	assign last_step  = (step_q == 5'(STEPS_PER_CHAR - 1));
	assign ram_re     = (state_q == S_EMIT) && !last_step && (step_kind(step_next) == K_DATA);
	assign raddr_full = {glyph_q, ptr_q};

	tcopw_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_font (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_full[ADDR_W-1:0]),
		.wdata(item.font_value),
		.re   (ram_re),
		.raddr(raddr_full[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	tcopw_fmt u_fmt (
		.step      (step_q),
		.row       (row_q),
		.column    (col_q),
		.glyph_data(ram_rdata),
		.out_byte  (fmt_byte),
		.is_data   (fmt_is_data)
	);

	assign glyph_w = 7'(char_q - CHAR_FIRST);
	assign code_ok = (char_q >= CHAR_FIRST) && (char_q <= CHAR_LAST)
		&& ({1'b0, glyph_w} < 8'(GLYPH_COUNT));
	assign wrap    = (col_q >= 5'(TEXT_COLUMNS));
	assign col_w   = wrap ? 5'd0 : col_q;
	assign row_w   = (wrap && (row_q < ROW_MAX)) ? 3'(row_q + 3'd1) : row_q;
	assign full_w  = (row_w >= 3'(TEXT_ROWS));
	assign pos_bad = (item.row >= 3'(TEXT_ROWS)) || (item.column >= 5'(TEXT_COLUMNS));

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			col_q    <= 5'd0;
			row_q    <= 3'd0;
			step_q   <= 5'd0;
			ptr_q    <= 4'd0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.action)
							ACT_PUT: state_q <= S_CHECK;
							ACT_SET: begin
								strobe_q <= 1'b1;
								if (!pos_bad) begin
									col_q <= item.column;
									row_q <= item.row;
								end
							end
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					step_q <= 5'd0;
					ptr_q  <= 4'd0;
					if (!code_ok) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						// wrap is kept even when the screen turns out full
						col_q <= col_w;
						row_q <= row_w;
						if (full_w) begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					step_q   <= step_next;
					if (ram_re) begin
						ptr_q <= 4'(ptr_q + 4'd1);
					end
					if (last_step) begin
						col_q   <= 5'(col_q + 5'd1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					char_q       <= item.char_code;
					res_q.has_byte <= 1'b0;
					res_q.out_byte <= 8'd0;
					res_q.is_data  <= 1'b0;
					res_q.status   <= pos_bad ? ST_BADPOS : ST_OK;
					res_q.last     <= 1'b1;
				end
			end
			S_CHECK: begin
				glyph_q        <= glyph_w;
				res_q.has_byte <= 1'b0;
				res_q.out_byte <= 8'd0;
				res_q.is_data  <= 1'b0;
				res_q.status   <= !code_ok ? ST_REJECT : ST_FULL;
				res_q.last     <= 1'b1;
			end
			S_EMIT: begin
				res_q.has_byte <= 1'b1;
				res_q.out_byte <= fmt_byte;
				res_q.is_data  <= fmt_is_data;
				res_q.status   <= ST_OK;
				res_q.last     <= last_step;
			end
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule
